/* sv/gwf_pkg.sv */
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared types, codes and helpers for the grid water flow block.
// ----------------------------------------------------------------------------
package gwf_pkg;

  // Grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int DIM_W      = 7;
  localparam int COORD_W    = 6;

  // Material codes
  localparam logic [1:0] K_EMPTY = 2'd0;
  localparam logic [1:0] K_WATER = 2'd1;
  localparam logic [1:0] K_STONE = 2'd2;

  // Sideways direction codes (two's complement)
  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_RIGHT = 2'b01;
  localparam logic [1:0] DIR_BAD   = 2'b10;
  localparam logic [1:0] DIR_LEFT  = 2'b11;

  // Item functions
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_ADD   = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FULL   = 2'd2;
  localparam logic [1:0] REG_LEDGE  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] units;
    logic [1:0] dir;
    logic       fall;
  } cell_t;

  // Neighbourhood slots, also the read order of a visit
  typedef enum logic [2:0] {
    SL_C, SL_L, SL_R, SL_D, SL_DL, SL_DR
  } slot_t;

  typedef enum logic [3:0] {
    ST_RCLR, ST_IDLE, ST_HADDR, ST_HRD, ST_HWR, ST_TCLR,
    ST_ADDR, ST_READ, ST_WAIT, ST_EVAL, ST_WR2, ST_DONE
  } state_t;

  // Context of one cell visit
  typedef struct packed {
    logic       vertical;
    logic       sub;
    logic       first_left;
    logic       in_l;
    logic       in_r;
    logic       in_d;
    logic [7:0] fu;
    logic [7:0] half;
    logic [8:0] lr;
  } flow_ctx_t;

  // Decision of one visit
  typedef struct packed {
    logic  move;
    slot_t t_sel;
    cell_t c_new;
    cell_t t_new;
  } flow_res_t;

  // Bring a cell to its canonical form
  function automatic cell_t cell_norm(cell_t c, logic [7:0] fu);
    cell_t r;
    r = c;
    if (c.kind != K_WATER || c.units == 8'd0) begin
      r = '0;
      r.kind = (c.kind == K_STONE) ? K_STONE : K_EMPTY;
    end else begin
      if (c.units > fu) r.units = fu;
      if (c.dir == DIR_BAD) r.dir = DIR_LEFT;
    end
    return r;
  endfunction

endpackage

/* sv/gwf_ram.sv */
// ----------------------------------------------------------------------------
// gwf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gwf_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/gwf_flow.sv */
// ----------------------------------------------------------------------------
// gwf_flow
// Transfer rules of one cell visit: down, diagonal and sideways moves.
// ----------------------------------------------------------------------------
module gwf_flow (
  input  gwf_pkg::flow_ctx_t ctx,
  input  gwf_pkg::cell_t     c_cell,
  input  gwf_pkg::cell_t     l_cell,
  input  gwf_pkg::cell_t     r_cell,
  input  gwf_pkg::cell_t     d_cell,
  input  gwf_pkg::cell_t     dl_cell,
  input  gwf_pkg::cell_t     dr_cell,
  input  logic               mv_c,
  input  logic               mv_l,
  input  logic               mv_r,
  output gwf_pkg::flow_res_t res
);
  import gwf_pkg::*;

  typedef struct packed {
    logic  ok;
    cell_t c;
    cell_t t;
  } mv_t;

  // Ledge release test on the source cell
  function automatic logic can_rel(cell_t s, logic [1:0] dirc, logic [7:0] ul,
                                   logic [7:0] ur, flow_ctx_t cx);
    logic [7:0] up;
    logic       ok;
    if (dirc == DIR_RIGHT) up = ul;
    else if (dirc == DIR_LEFT) up = ur;
    else up = (ul > ur) ? ul : ur;
    ok = 1'b0;
    if (s.kind == K_WATER) begin
      if (s.fall) ok = 1'b1;
      else if (s.units == cx.fu) ok = ({1'b0, s.units} + {1'b0, up}) >= cx.lr;
    end
    return ok;
  endfunction

  // Pour into a water target below
  function automatic mv_t pour_mv(cell_t s, cell_t t, logic [1:0] dirc, flow_ctx_t cx);
    mv_t        m;
    cell_t      sc;
    cell_t      tc;
    logic [7:0] room;
    logic [7:0] tr;
    room = cx.fu - t.units;
    tr = (s.units < room) ? s.units : room;
    sc = s;
    sc.units = s.units - tr;
    tc = t;
    tc.units = t.units + tr;
    tc.fall = 1'b0;
    tc.dir = dirc;
    m.ok = (t.units < cx.fu) && (tr != 8'd0);
    m.c = cell_norm(sc, cx.fu);
    m.t = cell_norm(tc, cx.fu);
    return m;
  endfunction

  // Whole cell drops into an empty target
  function automatic mv_t fall_mv(cell_t s, logic [1:0] dirc);
    mv_t m;
    m.ok = 1'b1;
    m.c = '0;
    m.t = s;
    m.t.dir = dirc;
    m.t.fall = 1'b1;
    return m;
  endfunction

  function automatic mv_t side_mv(cell_t s, cell_t t, logic in_t, logic m_t,
                                  logic [1:0] dirc, logic sup, flow_ctx_t cx);
    mv_t   m;
    cell_t sc;
    cell_t tc;
    m.ok = 1'b0;
    sc = s;
    tc = t;
    if (in_t && !m_t && !s.fall && sup) begin
      if (t.kind == K_EMPTY) begin
        m.ok = 1'b1;
        if (s.units == cx.fu) begin
          // full cell splits in two halves
          sc.units = cx.half;
          sc.fall = 1'b0;
          tc.kind = K_WATER;
          tc.units = cx.half;
          tc.dir = dirc;
          tc.fall = 1'b0;
        end else begin
          tc = s;
          tc.dir = dirc;
          tc.fall = 1'b0;
          sc = '0;
        end
      end else if (t.kind == K_WATER && t.units < s.units) begin
        m.ok = 1'b1;
        sc.units = s.units - 8'd1;
        tc.units = t.units + 8'd1;
        tc.dir = dirc;
        tc.fall = 1'b0;
      end
    end
    m.c = cell_norm(sc, cx.fu);
    m.t = cell_norm(tc, cx.fu);
    return m;
  endfunction

  logic       stone_dl;
  logic       stone_dr;
  logic [7:0] ul;
  logic [7:0] ur;
  logic       sup;
  logic       act;
  logic [1:0] first;
  logic [1:0] second;
  logic [1:0] ldir;
  logic [1:0] pref;
  logic [1:0] pref2;
  logic       blk;
  mv_t        down;
  mv_t        dg1;
  mv_t        dg2;
  mv_t        sd1;
  mv_t        sd2;

  // Neighbourhood summaries
  always_comb begin
    stone_dl = !(ctx.in_l && ctx.in_d) || dl_cell.kind == K_STONE;
    stone_dr = !(ctx.in_r && ctx.in_d) || dr_cell.kind == K_STONE;
    ul = (ctx.in_l && l_cell.kind == K_WATER) ? l_cell.units : 8'd0;
    ur = (ctx.in_r && r_cell.kind == K_WATER) ? r_cell.units : 8'd0;
    sup = !ctx.in_d || d_cell.kind == K_STONE ||
          (d_cell.kind == K_WATER && d_cell.units == ctx.fu);
    act = c_cell.kind == K_WATER && (!ctx.sub || c_cell.units == ctx.half) && !mv_c;
    first = ctx.first_left ? DIR_LEFT : DIR_RIGHT;
    second = {~first[1], first[0]};
    blk = !c_cell.fall && (sup || stone_dl || stone_dr);
    if (c_cell.dir != DIR_NONE) ldir = c_cell.dir;
    else if (stone_dl != stone_dr) ldir = stone_dl ? DIR_RIGHT : DIR_LEFT;
    else ldir = DIR_NONE;
    pref = (c_cell.dir != DIR_NONE) ? c_cell.dir : first;
    pref2 = {~pref[1], pref[0]};
  end

  // Candidate moves
  always_comb begin
    down = '0;
    if (d_cell.kind == K_WATER) begin
      down = pour_mv(c_cell, d_cell, c_cell.dir, ctx);
    end else if (d_cell.kind == K_EMPTY) begin
      down = fall_mv(c_cell, c_cell.dir);
      down.ok = c_cell.fall || !(stone_dl || stone_dr) ||
                can_rel(c_cell, ldir, ul, ur, ctx);
    end
    down.ok = down.ok && ctx.in_d;

    dg1 = '0;
    dg2 = '0;
    if (first == DIR_LEFT) begin
      if (dl_cell.kind == K_WATER) dg1 = pour_mv(c_cell, dl_cell, first, ctx);
      else if (dl_cell.kind == K_EMPTY) begin
        dg1 = fall_mv(c_cell, first);
        dg1.ok = !blk || can_rel(c_cell, first, ul, ur, ctx);
      end
      dg1.ok = dg1.ok && ctx.in_l && ctx.in_d;
      if (dr_cell.kind == K_WATER) dg2 = pour_mv(c_cell, dr_cell, second, ctx);
      else if (dr_cell.kind == K_EMPTY) begin
        dg2 = fall_mv(c_cell, second);
        dg2.ok = !blk || can_rel(c_cell, second, ul, ur, ctx);
      end
      dg2.ok = dg2.ok && ctx.in_r && ctx.in_d;
    end else begin
      if (dr_cell.kind == K_WATER) dg1 = pour_mv(c_cell, dr_cell, first, ctx);
      else if (dr_cell.kind == K_EMPTY) begin
        dg1 = fall_mv(c_cell, first);
        dg1.ok = !blk || can_rel(c_cell, first, ul, ur, ctx);
      end
      dg1.ok = dg1.ok && ctx.in_r && ctx.in_d;
      if (dl_cell.kind == K_WATER) dg2 = pour_mv(c_cell, dl_cell, second, ctx);
      else if (dl_cell.kind == K_EMPTY) begin
        dg2 = fall_mv(c_cell, second);
        dg2.ok = !blk || can_rel(c_cell, second, ul, ur, ctx);
      end
      dg2.ok = dg2.ok && ctx.in_l && ctx.in_d;
    end

    if (pref == DIR_LEFT) begin
      sd1 = side_mv(c_cell, l_cell, ctx.in_l, mv_l, pref, sup, ctx);
      sd2 = side_mv(c_cell, r_cell, ctx.in_r, mv_r, pref2, sup, ctx);
    end else begin
      sd1 = side_mv(c_cell, r_cell, ctx.in_r, mv_r, pref, sup, ctx);
      sd2 = side_mv(c_cell, l_cell, ctx.in_l, mv_l, pref2, sup, ctx);
    end
  end

  // First move that succeeds wins
  always_comb begin
    res = '0;
    res.t_sel = SL_D;
    if (act) begin
      if (ctx.vertical) begin
        priority if (down.ok) begin
          res.move = 1'b1; res.t_sel = SL_D; res.c_new = down.c; res.t_new = down.t;
        end else if (dg1.ok) begin
          res.move = 1'b1; res.t_sel = (first == DIR_LEFT) ? SL_DL : SL_DR;
          res.c_new = dg1.c; res.t_new = dg1.t;
        end else if (dg2.ok) begin
          res.move = 1'b1; res.t_sel = (second == DIR_LEFT) ? SL_DL : SL_DR;
          res.c_new = dg2.c; res.t_new = dg2.t;
        end else begin
          res.move = 1'b0;
        end
      end else begin
        priority if (sd1.ok) begin
          res.move = 1'b1; res.t_sel = (pref == DIR_LEFT) ? SL_L : SL_R;
          res.c_new = sd1.c; res.t_new = sd1.t;
        end else if (sd2.ok) begin
          res.move = 1'b1; res.t_sel = (pref2 == DIR_LEFT) ? SL_L : SL_R;
          res.c_new = sd2.c; res.t_new = sd2.t;
        end else begin
          res.move = 1'b0;
        end
      end
    end
  end

endmodule

/* sv/grid_water_flow_step_core.sv */
// ----------------------------------------------------------------------------
// grid_water_flow_step_core
// Cellular water simulation over a grid held in a cell memory.
// ----------------------------------------------------------------------------
// Items enter on the s_* stream (tuser selects tick, write, read or add; tdata
// carries the coordinate and the cell to write). Every item yields one result
// on the m_* stream: for a write, read or add inside the grid, the cell at the
// coordinate after the item, else a zero cell; plus an in-range flag in tuser.
// Registers are set over the APB port; the user must write them only while
// idle, as the block itself does not enforce it. One item is handled at a time.
// A write, read or add steps through address, read and write-back states to
// the result state; an item outside the grid goes straight to the result state.
// A tick runs two substeps, each a moved-map clear over all 4096 cells plus two
// scans of the grid (height-1 rows down, height rows across); each cell visit
// steps through an address state, six neighbour reads through the single
// cell-memory read port, a wait and a decision, plus a state where a move
// writes the second cell back. After reset both memories are swept to zero
// over all cells before the first item is taken. A finished result sits in the
// output register; the next item is accepted while it waits, and its own result
// waits for the register to drain when the receiver stalls.
// ----------------------------------------------------------------------------
module grid_water_flow_step_core (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // col[5:0] row[11:6] kind_in[13:12] units_in[21:14]
                                // dir_in[23:22] falling_in[24] zero[31:25]
  input  logic [1:0]  s_tuser,  // func[1:0]
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // kind_out[1:0] units_out[9:2] dir_out[11:10]
                                // falling_out[12] zero[15:13]
  output logic        m_tuser,  // in_range[0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gwf_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  // Configuration registers
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic [7:0] full_level;
  logic [8:0] ledge_release;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [7:0]       fu_raw;
  logic [7:0]       fu;
  logic [7:0]       half;

  // Control
  state_t state;
  state_t state_next;
  logic [ADDR_W-1:0] cnt;
  logic              sub;
  logic              parity;
  logic              vertical;
  logic [COORD_W-1:0] y;
  logic [COORD_W-1:0] o;
  slot_t             slot_cnt;
  slot_t             rd_slot;
  logic              rd_pend;

  // Item and visit payload
  logic [1:0]         op;
  logic [COORD_W-1:0] hcol;
  logic [COORD_W-1:0] hrow;
  cell_t              hcell;
  logic [ADDR_W-1:0]  base;
  logic [ADDR_W-1:0]  t_addr;
  cell_t              t_data;
  cell_t              nb_c, nb_l, nb_r, nb_d, nb_dl, nb_dr;
  logic               mv_c, mv_l, mv_r;
  cell_t              res_cell;
  logic               res_in;

  // Memory ports
  logic              c_we;
  logic [ADDR_W-1:0] c_waddr;
  cell_t             c_wdata;
  logic [12:0]       c_rdata;
  logic              m_we;
  logic [ADDR_W-1:0] m_waddr;
  logic              m_wdata;
  logic              m_rdata;
  logic [ADDR_W-1:0] rd_addr;

  // Datapath helpers
  logic [COORD_W-1:0] x;
  logic               p;
  logic               last_o;
  logic               last_row;
  logic               pass_end;
  logic               step_adv;
  logic [COORD_W-1:0] mul_y;
  logic [COORD_W-1:0] mul_x;
  logic [ADDR_W-1:0]  addr_calc;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic               in_grid;
  logic               out_free;
  cell_t              cur;
  cell_t              host_new;
  logic [8:0]         sum;
  flow_ctx_t          ctx;
  flow_res_t          fr;

  function automatic logic [ADDR_W-1:0] slot_addr(slot_t s, logic [ADDR_W-1:0] b,
                                                   logic [ADDR_W-1:0] w);
    logic [ADDR_W-1:0] a;
    unique case (s)
      SL_C:    a = b;
      SL_L:    a = b - ADDR_W'(1);
      SL_R:    a = b + ADDR_W'(1);
      SL_D:    a = b + w;
      SL_DL:   a = b + w - ADDR_W'(1);
      SL_DR:   a = b + w + ADDR_W'(1);
      default: a = b;
    endcase
    return a;
  endfunction

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= 7'd64;
      grid_height   <= 7'd64;
      full_level    <= 8'd16;
      ledge_release <= 9'd24;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_WIDTH:  grid_width    <= pwdata[6:0];
        REG_HEIGHT: grid_height   <= pwdata[6:0];
        REG_FULL:   full_level    <= pwdata[7:0];
        REG_LEDGE:  ledge_release <= pwdata[8:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {25'd0, grid_width};
      REG_HEIGHT: prdata = {25'd0, grid_height};
      REG_FULL:   prdata = {24'd0, full_level};
      REG_LEDGE:  prdata = {23'd0, ledge_release};
      default:    prdata = '0;
    endcase
  end

  // Effective sizes and levels
  always_comb begin
    if (grid_width == 7'd0) w_eff = 7'd1;
    else if (grid_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = grid_width;
    if (grid_height == 7'd0) h_eff = 7'd1;
    else if (grid_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = grid_height;
    fu_raw = {full_level[7:1], 1'b0};
    fu = (fu_raw < 8'd2) ? 8'd2 : fu_raw;
    half = {1'b0, fu[7:1]};
  end

  // Scan position
  assign p        = parity ^ sub;
  assign x        = (vertical ^ p) ? o : COORD_W'(w_eff - 7'd1 - {1'b0, o});
  assign last_o   = {1'b0, o} == (w_eff - 7'd1);
  assign last_row = vertical ? (y == '0) : ({1'b0, y} == (h_eff - 7'd1));
  assign pass_end = last_o && last_row && !vertical;
  assign step_adv = (state == ST_EVAL && !fr.move) || state == ST_WR2;

  // Shared row-major address: row * width + column
  assign mul_y     = (state == ST_HADDR) ? hrow : y;
  assign mul_x     = (state == ST_HADDR) ? hcol : x;
  assign addr_calc = ADDR_W'(14'(mul_y) * 14'(w_eff) + 14'(mul_x));

  // Input decode
  assign in_col   = s_tdata[5:0];
  assign in_row   = s_tdata[11:6];
  assign in_grid  = ({1'b0, in_col} < w_eff) && ({1'b0, in_row} < h_eff);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == ST_IDLE;

  // Host write and add on the fetched cell
  always_comb begin
    cur = cell_t'(c_rdata);
    sum = {1'b0, (cur.kind == K_WATER) ? cur.units : 8'd0} + {1'b0, hcell.units};
    unique case (op)
      FUNC_WRITE: host_new = cell_norm(hcell, fu);
      FUNC_ADD: begin
        host_new = cur;
        if (hcell.units != 8'd0 && cur.kind != K_STONE) begin
          host_new.kind  = K_WATER;
          host_new.units = (sum < {1'b0, fu}) ? sum[7:0] : fu;
          host_new.dir   = DIR_NONE;
          host_new.fall  = 1'b0;
        end
      end
      default: host_new = cur;
    endcase
  end

  // Visit context
  always_comb begin
    ctx.vertical   = vertical;
    ctx.sub        = sub;
    ctx.first_left = (p ^ x[0] ^ y[0]) == 1'b0;
    ctx.in_l       = x != '0;
    ctx.in_r       = ({1'b0, x} + 7'd1) < w_eff;
    ctx.in_d       = ({1'b0, y} + 7'd1) < h_eff;
    ctx.fu         = fu;
    ctx.half       = half;
    ctx.lr         = ledge_release;
  end

  gwf_flow u_flow (
    .ctx     (ctx),
    .c_cell  (nb_c),
    .l_cell  (nb_l),
    .r_cell  (nb_r),
    .d_cell  (nb_d),
    .dl_cell (nb_dl),
    .dr_cell (nb_dr),
    .mv_c    (mv_c),
    .mv_l    (mv_l),
    .mv_r    (mv_r),
    .res     (fr)
  );

  gwf_ram #(.WIDTH(13), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (rd_addr),
    .rdata (c_rdata)
  );

  gwf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_moved_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (rd_addr),
    .rdata (m_rdata)
  );

  // Next state and memory control
  always_comb begin
    state_next = state;
    c_we    = 1'b0;
    c_waddr = cnt;
    c_wdata = '0;
    m_we    = 1'b0;
    m_waddr = cnt;
    m_wdata = 1'b0;
    rd_addr = base;
    unique case (state)
      ST_RCLR: begin
        c_we = 1'b1;
        m_we = 1'b1;
        if (cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == FUNC_TICK) state_next = ST_TCLR;
          else if (!in_grid) state_next = ST_DONE;
          else state_next = ST_HADDR;
        end
      end
      ST_HADDR: state_next = ST_HRD;
      ST_HRD:   state_next = ST_HWR;
      ST_HWR: begin
        c_we    = (op == FUNC_WRITE) || (op == FUNC_ADD);
        c_waddr = base;
        c_wdata = host_new;
        state_next = ST_DONE;
      end
      ST_TCLR: begin
        m_we = 1'b1;
        if (cnt == LAST_ADDR) state_next = ST_ADDR;
      end
      ST_ADDR: state_next = ST_READ;
      ST_READ: begin
        rd_addr = slot_addr(slot_cnt, base, ADDR_W'(w_eff));
        if (slot_cnt == SL_DR) state_next = ST_WAIT;
      end
      ST_WAIT: state_next = ST_EVAL;
      ST_EVAL: begin
        if (fr.move) begin
          c_we    = 1'b1;
          c_waddr = base;
          c_wdata = fr.c_new;
          m_we    = 1'b1;
          m_waddr = base;
          m_wdata = 1'b1;
          state_next = ST_WR2;
        end else if (pass_end) begin
          state_next = sub ? ST_DONE : ST_TCLR;
        end else begin
          state_next = ST_ADDR;
        end
      end
      ST_WR2: begin
        c_we    = 1'b1;
        c_waddr = t_addr;
        c_wdata = t_data;
        m_we    = 1'b1;
        m_waddr = t_addr;
        m_wdata = 1'b1;
        if (pass_end) state_next = sub ? ST_DONE : ST_TCLR;
        else state_next = ST_ADDR;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_RCLR;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_RCLR;
    else state <= state_next;
  end

  // Sequencer counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      sub      <= 1'b0;
      parity   <= 1'b0;
      vertical <= 1'b0;
      y        <= '0;
      o        <= '0;
      slot_cnt <= SL_C;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= state == ST_READ;
      if (state == ST_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_RCLR: cnt <= cnt + ADDR_W'(1);
        ST_IDLE: begin
          if (s_tvalid) begin
            sub <= 1'b0;
            cnt <= '0;
          end
        end
        ST_TCLR: begin
          cnt <= cnt + ADDR_W'(1);
          if (cnt == LAST_ADDR) begin
            o <= '0;
            if (h_eff >= 7'd2) begin
              vertical <= 1'b1;
              y <= COORD_W'(h_eff - 7'd2);
            end else begin
              vertical <= 1'b0;
              y <= '0;
            end
          end
        end
        ST_ADDR: slot_cnt <= SL_C;
        ST_READ: begin
          if (slot_cnt != SL_DR) slot_cnt <= slot_t'(slot_cnt + 3'd1);
        end
        default: ;
      endcase
      // next cell of the scan
      if (step_adv) begin
        if (!last_o) begin
          o <= o + COORD_W'(1);
        end else begin
          o <= '0;
          if (!last_row) begin
            y <= vertical ? y - COORD_W'(1) : y + COORD_W'(1);
          end else if (vertical) begin
            vertical <= 1'b0;
            y <= '0;
          end else if (!sub) begin
            sub <= 1'b1;
            cnt <= '0;
          end else begin
            parity <= ~parity;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      op          <= s_tuser;
      hcol        <= in_col;
      hrow        <= in_row;
      hcell.kind  <= s_tdata[13:12];
      hcell.units <= s_tdata[21:14];
      hcell.dir   <= s_tdata[23:22];
      hcell.fall  <= s_tdata[24];
      res_cell    <= '0;
      res_in      <= (s_tuser == FUNC_TICK) || in_grid;
    end
    if (state == ST_HADDR || state == ST_ADDR) base <= addr_calc;
    if (state == ST_HWR) res_cell <= host_new;
    if (state == ST_EVAL) begin
      t_addr <= slot_addr(fr.t_sel, base, ADDR_W'(w_eff));
      t_data <= fr.t_new;
    end
    // capture the neighbourhood one slot a cycle
    if (rd_pend) begin
      unique case (rd_slot)
        SL_C:    begin nb_c <= cell_t'(c_rdata); mv_c <= m_rdata; end
        SL_L:    begin nb_l <= cell_t'(c_rdata); mv_l <= m_rdata; end
        SL_R:    begin nb_r <= cell_t'(c_rdata); mv_r <= m_rdata; end
        SL_D:    nb_d  <= cell_t'(c_rdata);
        SL_DL:   nb_dl <= cell_t'(c_rdata);
        SL_DR:   nb_dr <= cell_t'(c_rdata);
        default: ;
      endcase
    end
    if (state == ST_READ) rd_slot <= slot_cnt;
    if (state == ST_DONE && out_free) begin
      m_tdata <= {3'd0, res_cell.fall, res_cell.dir, res_cell.units, res_cell.kind};
      m_tuser <= res_in;
    end
  end

  // Checks
  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !c_we && !m_we)
    else $error("memory write during neighbourhood read");

  a_accept_one: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in work");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> !c_we && !m_we)
    else $error("memory written while result waits");

  a_wr2_after_move: assert property (@(posedge clk) disable iff (rst)
    state == ST_WR2 |-> $past(state) == ST_EVAL && $past(fr.move))
    else $error("target write-back without a move");

endmodule

/* dv/gwf_flow_checker.sv */
// ----------------------------------------------------------------------------
// gwf_flow_checker
// Watches the item, result and register channels of the grid water flow core,
// keeps its own copy of the grid and predicts every result from it.
// ----------------------------------------------------------------------------
module gwf_flow_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // col[5:0] row[11:6] kind_in[13:12] units_in[21:14]
                                 // dir_in[23:22] falling_in[24]
  input  logic [1:0]  s_tuser,   // func[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // kind_out[1:0] units_out[9:2] dir_out[11:10]
                                 // falling_out[12]
  input  logic        m_tuser,   // in_range[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding,
  output int          ticks_seen
);
  import gwf_pkg::*;

  typedef struct packed {
    cell_t wcell;
    logic  in_range;
  } cell_view_t;

  cell_t      grid_mem [CELLS];
  bit         moved    [CELLS];
  bit         parity;
  logic [6:0] cfg_w, cfg_h;
  logic [7:0] cfg_full;
  logic [8:0] cfg_ledge;
  cell_view_t expected_q[$];

  assign outstanding = expected_q.size();

  // Effective geometry and levels
  function automatic int eff_w();
    int v;
    v = (cfg_w == 0) ? 1 : int'(cfg_w);
    return (v > MAX_WIDTH) ? MAX_WIDTH : v;
  endfunction

  function automatic int eff_h();
    int v;
    v = (cfg_h == 0) ? 1 : int'(cfg_h);
    return (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
  endfunction

  function automatic int full_u();
    int v;
    v = int'(cfg_full & 8'hFE);
    return (v < 2) ? 2 : v;
  endfunction

  function automatic bit inside_grid(int x, int y);
    return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
  endfunction

  function automatic int cell_idx(int x, int y);
    return y * eff_w() + x;
  endfunction

  function automatic int dir_val(logic [1:0] d);
    case (d)
      DIR_RIGHT: return 1;
      DIR_LEFT:  return -1;
      DIR_BAD:   return -2;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [1:0] dir_code(int d);
    return (d > 0) ? DIR_RIGHT : (d < 0) ? DIR_LEFT : DIR_NONE;
  endfunction

  function automatic cell_t tidy(cell_t c);
    cell_t r;
    r = c;
    if (c.kind != K_WATER || c.units == 0) begin
      r = '0;
      if (c.kind == K_STONE) r.kind = K_STONE;
    end else begin
      if (int'(c.units) > full_u()) r.units = 8'(full_u());
      if (c.dir == DIR_BAD) r.dir = DIR_LEFT;
    end
    return r;
  endfunction

  function automatic int units_at(int x, int y);
    if (!inside_grid(x, y)) return 0;
    return (grid_mem[cell_idx(x, y)].kind == K_WATER) ? int'(grid_mem[cell_idx(x, y)].units) : 0;
  endfunction

  // Outside cells count as stone
  function automatic bit rock_at(int x, int y);
    if (!inside_grid(x, y)) return 1'b1;
    return grid_mem[cell_idx(x, y)].kind == K_STONE;
  endfunction

  function automatic bit supported(int x, int y);
    cell_t b;
    if (y + 1 >= eff_h()) return 1'b1;
    b = grid_mem[cell_idx(x, y + 1)];
    return b.kind == K_STONE || (b.kind == K_WATER && int'(b.units) == full_u());
  endfunction

  function automatic bit eligible(cell_t c, int sub);
    if (c.kind != K_WATER) return 1'b0;
    return sub == 0 || int'(c.units) == full_u() / 2;
  endfunction

  function automatic int ledge_dir(int x, int y, cell_t c);
    bit l, r;
    if (dir_val(c.dir) != 0) return dir_val(c.dir);
    l = rock_at(x - 1, y + 1);
    r = rock_at(x + 1, y + 1);
    if (l != r) return l ? 1 : -1;
    return 0;
  endfunction

  function automatic bit can_release(int x, int y, int d);
    cell_t s;
    int    up, a, b;
    s = grid_mem[cell_idx(x, y)];
    if (s.kind != K_WATER) return 1'b0;
    if (s.fall) return 1'b1;
    if (int'(s.units) != full_u()) return 1'b0;
    if (d != 0) begin
      up = units_at(x - d, y);
    end else begin
      a  = units_at(x - 1, y);
      b  = units_at(x + 1, y);
      up = (a > b) ? a : b;
    end
    return int'(s.units) + up >= int'(cfg_ledge);
  endfunction

  function automatic void commit(int si, int ti, cell_t s, cell_t t);
    grid_mem[si] = s;
    grid_mem[ti] = t;
    moved[si]    = 1'b1;
    moved[ti]    = 1'b1;
  endfunction

  function automatic bit pour(inout cell_t s, inout cell_t t);
    int room, tr;
    if (int'(t.units) >= full_u()) return 1'b0;
    room    = full_u() - int'(t.units);
    tr      = (int'(s.units) < room) ? int'(s.units) : room;
    s.units = 8'(int'(s.units) - tr);
    t.units = 8'(int'(t.units) + tr);
    t.fall  = 1'b0;
    return tr != 0;
  endfunction

  function automatic bit move_down(int x, int y, int sub);
    int    si, ti;
    cell_t s, t;
    bit    ledge;
    if (y + 1 >= eff_h()) return 1'b0;
    si = cell_idx(x, y);
    ti = cell_idx(x, y + 1);
    s  = grid_mem[si];
    t  = grid_mem[ti];
    if (!eligible(s, sub) || moved[si] || t.kind == K_STONE) return 1'b0;
    if (t.kind == K_WATER) begin
      if (!pour(s, t)) return 1'b0;
      t.dir = s.dir;
      commit(si, ti, tidy(s), tidy(t));
      return 1'b1;
    end
    if (t.kind != K_EMPTY) return 1'b0;
    ledge = !s.fall && (rock_at(x - 1, y + 1) || rock_at(x + 1, y + 1));
    if (ledge && !can_release(x, y, ledge_dir(x, y, s))) return 1'b0;
    s.fall = 1'b1;
    commit(si, ti, '0, s);
    return 1'b1;
  endfunction

  function automatic bit move_diag(int x, int y, int d, int sub);
    int    si, ti;
    cell_t s, t;
    bit    beside;
    if (!inside_grid(x + d, y + 1)) return 1'b0;
    si = cell_idx(x, y);
    ti = cell_idx(x + d, y + 1);
    s  = grid_mem[si];
    t  = grid_mem[ti];
    if (!eligible(s, sub) || moved[si] || t.kind == K_STONE) return 1'b0;
    if (t.kind == K_WATER) begin
      if (int'(t.units) >= full_u()) return 1'b0;
      void'(pour(s, t));
      t.dir = dir_code(d);
      commit(si, ti, tidy(s), tidy(t));
      return 1'b1;
    end
    if (t.kind != K_EMPTY) return 1'b0;
    beside = rock_at(x - 1, y + 1) || rock_at(x + 1, y + 1);
    if (!s.fall && (supported(x, y) || beside) && !can_release(x, y, d)) return 1'b0;
    s.dir  = dir_code(d);
    s.fall = 1'b1;
    commit(si, ti, '0, s);
    return 1'b1;
  endfunction

  function automatic bit move_side(int x, int y, int d, int sub);
    int    si, ti;
    cell_t s, t;
    if (!inside_grid(x + d, y)) return 1'b0;
    si = cell_idx(x, y);
    ti = cell_idx(x + d, y);
    s  = grid_mem[si];
    t  = grid_mem[ti];
    if (!eligible(s, sub) || moved[si] || moved[ti]) return 1'b0;
    if (s.fall || !supported(x, y) || t.kind == K_STONE) return 1'b0;
    if (t.kind == K_EMPTY) begin
      if (int'(s.units) == full_u()) begin
        // full cell splits into two halves
        s.units = 8'(full_u() / 2);
        s.fall  = 1'b0;
        t.kind  = K_WATER;
        t.units = 8'(full_u() / 2);
        t.dir   = dir_code(d);
        t.fall  = 1'b0;
      end else begin
        t      = s;
        t.dir  = dir_code(d);
        t.fall = 1'b0;
        s      = '0;
      end
    end else if (t.kind == K_WATER && t.units < s.units) begin
      s.units = s.units - 8'd1;
      t.units = t.units + 8'd1;
      t.dir   = dir_code(d);
      t.fall  = 1'b0;
    end else begin
      return 1'b0;
    end
    commit(si, ti, tidy(s), tidy(t));
    return 1'b1;
  endfunction

  // Two substeps, each a vertical pass bottom-up, then sideways levelling top-down
  function automatic void run_tick();
    int w, h, p, x, pref, first;
    w = eff_w();
    h = eff_h();
    for (int sub = 0; sub < 2; sub++) begin
      p = (int'(parity) + sub) & 1;
      foreach (moved[i]) moved[i] = 1'b0;
      for (int y = h - 2; y >= 0; y--) begin
        for (int o = 0; o < w; o++) begin
          x = (p == 0) ? o : w - 1 - o;
          if (!eligible(grid_mem[cell_idx(x, y)], sub) || moved[cell_idx(x, y)]) continue;
          if (move_down(x, y, sub)) continue;
          first = (((p + x + y) & 1) == 0) ? -1 : 1;
          if (move_diag(x, y, first, sub)) continue;
          void'(move_diag(x, y, -first, sub));
        end
      end
      for (int y = 0; y < h; y++) begin
        for (int o = 0; o < w; o++) begin
          x = (p != 0) ? o : w - 1 - o;
          if (!eligible(grid_mem[cell_idx(x, y)], sub) || moved[cell_idx(x, y)]) continue;
          pref = dir_val(grid_mem[cell_idx(x, y)].dir);
          if (pref == 0) pref = (((p + x + y) & 1) == 0) ? -1 : 1;
          if (move_side(x, y, pref, sub)) continue;
          void'(move_side(x, y, -pref, sub));
        end
      end
    end
    parity = ~parity;
  endfunction

  // Apply one item to the grid copy and return the cell it reports
  function automatic cell_view_t apply_item(logic [1:0] func, logic [31:0] d);
    cell_view_t r;
    cell_t      w;
    int         x, y, i, sum;
    r          = '0;
    r.in_range = 1'b1;
    x          = int'(d[5:0]);
    y          = int'(d[11:6]);
    if (func == FUNC_TICK) begin
      run_tick();
    end else if (!inside_grid(x, y)) begin
      r.in_range = 1'b0;
    end else begin
      i = cell_idx(x, y);
      if (func == FUNC_WRITE) begin
        w.kind  = d[13:12];
        w.units = d[21:14];
        w.dir   = d[23:22];
        w.fall  = d[24];
        grid_mem[i] = tidy(w);
      end else if (func == FUNC_ADD && d[21:14] != 0 && grid_mem[i].kind != K_STONE) begin
        sum = ((grid_mem[i].kind == K_WATER) ? int'(grid_mem[i].units) : 0) + int'(d[21:14]);
        grid_mem[i].kind  = K_WATER;
        grid_mem[i].units = 8'((sum < full_u()) ? sum : full_u());
        grid_mem[i].dir   = DIR_NONE;
        grid_mem[i].fall  = 1'b0;
      end
      r.wcell = grid_mem[i];
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Observe all channels at the rising edge
  always @(posedge clk) begin
    cell_view_t want;
    if (rst) begin
      foreach (grid_mem[i]) grid_mem[i] = '0;
      foreach (moved[i]) moved[i] = 1'b0;
      parity     = 1'b0;
      cfg_w      = 7'd64;
      cfg_h      = 7'd64;
      cfg_full   = 8'd16;
      cfg_ledge  = 9'd24;
      mismatches = 0;
      ticks_seen = 0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, tdata", int'(m_tdata), -1);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[1:0] != want.wcell.kind)
            report("kind_out", int'(m_tdata[1:0]), int'(want.wcell.kind));
          if (m_tdata[9:2] != want.wcell.units)
            report("units_out", int'(m_tdata[9:2]), int'(want.wcell.units));
          if (m_tdata[11:10] != want.wcell.dir)
            report("dir_out", int'(m_tdata[11:10]), int'(want.wcell.dir));
          if (m_tdata[12] != want.wcell.fall)
            report("falling_out", int'(m_tdata[12]), int'(want.wcell.fall));
          if (m_tuser != want.in_range)
            report("in_range", int'(m_tuser), int'(want.in_range));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == FUNC_TICK) ticks_seen++;
        expected_q.push_back(apply_item(s_tuser, s_tdata));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:  cfg_w     = pwdata[6:0];
          REG_HEIGHT: cfg_h     = pwdata[6:0];
          REG_FULL:   cfg_full  = pwdata[7:0];
          REG_LEDGE:  cfg_ledge = pwdata[8:0];
        endcase
      end
    end
  end

endmodule

/* dv/tb_grid_water_flow_step_core.sv */
// ----------------------------------------------------------------------------
// tb_grid_water_flow_step_core
// Drives directed and random items through several grid settings with random
// gaps and stalls on both streams; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_grid_water_flow_step_core;
  import gwf_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // col[5:0] row[11:6] kind_in[13:12] units_in[21:14]
                              // dir_in[23:22] falling_in[24] zero[31:25]
  logic [1:0]  s_tuser = '0;  // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // kind_out[1:0] units_out[9:2] dir_out[11:10] falling_out[12]
  logic        m_tuser;       // in_range[0]
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  mismatches, outstanding, ticks_seen;
  int  items_sent = 0;
  int  cycles = 0;
  int  settings_run = 1;
  bit  no_idle = 1'b0;
  bit  hold_out = 1'b0;
  int  cur_w = 64, cur_h = 64, cur_full = 16;

  always #5 clk = ~clk;

  grid_water_flow_step_core dut (.*);

  gwf_flow_checker chk (.*);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_grid_water_flow_step_core NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic [1:0] func, int col, int row, logic [1:0] kind, int units,
                      logic [1:0] dir, logic fall);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {7'd0, fall, dir, units[7:0], kind, row[5:0], col[5:0]};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Mostly water writes and ticks inside the grid, with some noise
  task automatic rand_item();
    int col, row, units;
    logic [1:0] func, kind;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: func = FUNC_WRITE;
      9, 10, 11:                 func = FUNC_ADD;
      12, 13, 14:                func = FUNC_READ;
      default:                   func = FUNC_TICK;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      col = $urandom_range(0, 63);
      row = $urandom_range(0, 63);
    end else begin
      col = $urandom_range(0, cur_w - 1);
      row = $urandom_range(0, cur_h - 1);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: kind = K_WATER;
      7, 8:                kind = K_STONE;
      default:             kind = 2'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 3))
      0:       units = cur_full;
      1:       units = cur_full / 2;
      default: units = $urandom_range(0, 255);
    endcase
    send(func, col, row, kind, units, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_out = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  // Withdraw the last item, then wait for every result
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] index, int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int w, int h, int full, int ledge);
    drain();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_FULL, full);
    reg_write(REG_LEDGE, ledge);
    cur_w    = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    cur_h    = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    cur_full = ((full & 254) < 2) ? 2 : (full & 254);
    settings_run++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Full grid at reset settings: normalising writes, adds, a full-size tick
    send(FUNC_WRITE, 0, 0, K_WATER, 255, DIR_BAD, 1'b1);
    send(FUNC_WRITE, 63, 63, K_STONE, 200, DIR_RIGHT, 1'b1);
    send(FUNC_WRITE, 5, 5, 2'd3, 9, DIR_LEFT, 1'b0);
    send(FUNC_WRITE, 6, 5, K_WATER, 0, DIR_RIGHT, 1'b1);
    send(FUNC_READ, 63, 63, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_READ, 0, 0, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_ADD, 7, 7, K_EMPTY, 255, DIR_NONE, 1'b0);
    send(FUNC_ADD, 63, 63, K_EMPTY, 5, DIR_NONE, 1'b0);
    send(FUNC_ADD, 0, 0, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_ADD, 7, 7, K_EMPTY, 3, DIR_NONE, 1'b0);
    send(FUNC_WRITE, 10, 62, K_WATER, 8, DIR_NONE, 1'b0);
    send(FUNC_TICK, 0, 0, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_READ, 10, 63, K_EMPTY, 0, DIR_NONE, 1'b0);

    // Small grid: a full cell on a ledge, out-of-range coordinates
    configure(4, 5, 16, 24);
    send(FUNC_WRITE, 1, 2, K_WATER, 16, DIR_NONE, 1'b0);
    send(FUNC_WRITE, 0, 3, K_STONE, 0, DIR_NONE, 1'b0);
    send(FUNC_WRITE, 2, 2, K_WATER, 16, DIR_NONE, 1'b0);
    send(FUNC_TICK, 0, 0, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_READ, 1, 3, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_WRITE, 5, 1, K_WATER, 4, DIR_NONE, 1'b0);
    send(FUNC_ADD, 0, 7, K_EMPTY, 4, DIR_NONE, 1'b0);
    send(FUNC_TICK, 0, 0, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_TICK, 0, 0, K_EMPTY, 0, DIR_NONE, 1'b0);
    send(FUNC_READ, 3, 4, K_EMPTY, 0, DIR_NONE, 1'b0);

    // Long receiver hold-off while items keep coming
    drain();
    hold_out = 1'b1;
    repeat (6) send(FUNC_READ, $urandom_range(0, 3), $urandom_range(0, 4), K_EMPTY, 0,
                    DIR_NONE, 1'b0);
    repeat (18) rand_item();

    configure(8, 8, 254, 508);
    repeat (18) rand_item();

    configure(0, 100, 7, 0);
    repeat (14) rand_item();

    // Back-to-back stretch with no idling
    configure(127, 0, 1, 300);
    no_idle = 1'b1;
    repeat (10) rand_item();
    no_idle = 1'b0;

    configure(6, 6, 16, 20);
    repeat (15) rand_item();

    @(negedge clk);
    s_tvalid <= 1'b0;
    drain();
    repeat (20) @(negedge clk);

    $display("Covered %0d items (%0d ticks) over %0d grid settings, extremes included.",
             items_sent, ticks_seen, settings_run);
    if (mismatches == 0) begin
      $display("tb_grid_water_flow_step_core OK");
    end else begin
      $display("tb_grid_water_flow_step_core NOT OK");
    end
    $finish;
  end

endmodule
